[rtl/mandelbrot_escape_time_defines.svh]
// Assertion macros shared by the escape-time RTL.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MET_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("escape-time assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MET_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("escape-time assertion failed");

`endif

[rtl/met_pkg.sv]
// Shared types and constants for the escape-time block.
`timescale 1ns / 1ps

package met_pkg;

   // Width of one coordinate component on the input item.
   localparam int unsigned COORD_W = 32;
   // Width of the iteration counter, the limit register and the shade.
   localparam int unsigned COUNT_W = 8;

   // Limit register value after reset.
   localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd100;
   // Shade of points that never escape, also the saturation level.
   localparam logic [COUNT_W-1:0] SHADE_MAX = 8'd255;

   // Division by five through a reciprocal: n / 5 == (n * 205) >> 10 for n < 1024.
   localparam logic [7:0] DIV5_RECIP = 8'd205;
   localparam int unsigned DIV5_SHIFT = 10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;  // take a new coordinate, z = c, count = 0
      logic step;  // one iteration: z = z*z + c, count + 1
      logic emit;  // write the result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;  // escape reached or count at the limit
   } status_type;

endpackage

[rtl/met_datapath.sv]
// Escape-time datapath: z registers, three multipliers, limit test and result register.
`timescale 1ns / 1ps

module met_datapath #(
   parameter int unsigned FRAC_BITS = 28
) (
   input  logic                                clock,
   input  logic                                reset,
   input  met_pkg::cmd_type                    cmd,
   output met_pkg::status_type                 status,
   input  logic [2*met_pkg::COORD_W-1:0]       req_tdata,
   input  logic                                csr_we,
   input  logic [met_pkg::COUNT_W-1:0]         csr_wdata,
   output logic [met_pkg::COUNT_W-1:0]         shade,
   output logic [met_pkg::COUNT_W-1:0]         iteration_count,
   output logic                                escaped
);

   localparam int unsigned CW = met_pkg::COORD_W;
   localparam int unsigned NW = met_pkg::COUNT_W;
   // z carries the coordinate range plus the |z*z| < 4 growth with margin.
   localparam int unsigned ZW = ((FRAC_BITS + 2 > CW - 1) ? FRAC_BITS + 2 : CW - 1) + 3;
   localparam int unsigned PW = 2 * ZW;
   localparam int unsigned SW = PW - FRAC_BITS + 1;
   localparam logic signed [SW-1:0] FOUR = SW'(4) << FRAC_BITS;

   logic signed [CW-1:0] cr_ff, cr_in;
   logic signed [CW-1:0] ci_ff, ci_in;
   logic signed [ZW-1:0] zr_ff, zr_in;
   logic signed [ZW-1:0] zi_ff, zi_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [NW-1:0]        max_iter_ff, max_iter_in;

   logic signed [PW-1:0] prod_rr_ff, prod_rr_in;
   logic signed [PW-1:0] prod_ii_ff, prod_ii_in;
   logic signed [PW-1:0] prod_ri_ff, prod_ri_in;

   logic [NW-1:0] shade_ff, shade_in;
   logic [NW-1:0] count_out_ff, count_out_in;
   logic          escaped_ff, escaped_in;

   logic signed [PW-FRAC_BITS-1:0] zr2;
   logic signed [PW-FRAC_BITS-1:0] zi2;
   logic signed [SW-1:0]           zri2;
   logic signed [SW-1:0]           mag;
   logic signed [SW-1:0]           zr_sum;
   logic signed [SW-1:0]           zi_sum;
   logic                           at_limit;
   logic [2*NW-1:0]                div5_prod;
   logic [NW:0]                    shade_sum;

   // Limit register, written from the configuration port.
   always_comb begin
      max_iter_in = csr_we ? csr_wdata : max_iter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= met_pkg::MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   // Products of the current z, registered every cycle.
   assign prod_rr_in = PW'(zr_ff) * PW'(zr_ff);
   assign prod_ii_in = PW'(zi_ff) * PW'(zi_ff);
   assign prod_ri_in = PW'(zr_ff) * PW'(zi_ff);

   // Floor of each product by the fraction scale; the cross term keeps its factor of two.
   assign zr2   = prod_rr_ff[PW-1:FRAC_BITS];
   assign zi2   = prod_ii_ff[PW-1:FRAC_BITS];
   assign zri2  = prod_ri_ff[PW-1:FRAC_BITS-1];

   // Escape and limit test.
   assign mag      = SW'(zr2) + SW'(zi2);
   assign at_limit = (count_ff == max_iter_ff);
   assign status.stop = (mag >= FOUR) || at_limit;

   // Next z for one iteration.
   assign zr_sum = SW'(zr2) - SW'(zi2) + SW'(cr_ff);
   assign zi_sum = zri2 + SW'(ci_ff);

   // Iteration state updates.
   always_comb begin
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      count_in = count_ff;
      if (cmd.load) begin
         cr_in    = req_tdata[CW-1:0];
         ci_in    = req_tdata[2*CW-1:CW];
         zr_in    = ZW'(signed'(req_tdata[CW-1:0]));
         zi_in    = ZW'(signed'(req_tdata[2*CW-1:CW]));
         count_in = '0;
      end else if (cmd.step) begin
         zr_in    = zr_sum[ZW-1:0];
         zi_in    = zi_sum[ZW-1:0];
         count_in = count_ff + NW'(1);
      end
   end

   // Shade: count + count / 5, saturated, or full white for points that stay bounded.
   assign div5_prod = NW'(count_ff) * met_pkg::DIV5_RECIP;
   assign shade_sum = {1'b0, count_ff} + (NW+1)'(div5_prod[2*NW-1:met_pkg::DIV5_SHIFT]);

   always_comb begin
      shade_in     = shade_ff;
      count_out_in = count_out_ff;
      escaped_in   = escaped_ff;
      if (cmd.emit) begin
         count_out_in = count_ff;
         escaped_in   = !at_limit;
         if (at_limit || shade_sum[NW]) begin
            shade_in = met_pkg::SHADE_MAX;
         end else begin
            shade_in = shade_sum[NW-1:0];
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      count_ff     <= count_in;
      prod_rr_ff   <= prod_rr_in;
      prod_ii_ff   <= prod_ii_in;
      prod_ri_ff   <= prod_ri_in;
      shade_ff     <= shade_in;
      count_out_ff <= count_out_in;
      escaped_ff   <= escaped_in;
   end

   assign shade           = shade_ff;
   assign iteration_count = count_out_ff;
   assign escaped         = escaped_ff;

endmodule

[rtl/met_ctrl.sv]
// Escape-time controller: item handshake, iteration sequencing and output valid.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_defines.svh"

module met_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output met_pkg::cmd_type    cmd,
   input  met_pkg::status_type status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MUL   = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       accept;
   logic       slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   // Sequencing: load, then alternate product and test cycles until stop, then emit once the output slot is free.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!status.stop) begin
               cmd.step = 1'b1;
               state_in = S_MUL;
            end else if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid: set by a new result, cleared when the result is taken.
   always_comb begin
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   // An accepted item always passes through the product state and then the test state.
   `MET_ASSERT_NEXT(a_accept_seq, clock, reset, accept, state_ff == S_MUL ##1 state_ff == S_CHECK)
   // A finished item shows up as a valid result and frees the input side.
   `MET_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_tvalid_ff && state_ff == S_IDLE)
   // A finished item waits in the test state while the output register is full.
   `MET_ASSERT_NEXT(a_hold_blocked, clock, reset,
      state_ff == S_CHECK && status.stop && rsp_tvalid_ff && !rsp_tready,
      state_ff == S_CHECK && rsp_tvalid_ff)

endmodule

[rtl/mandelbrot_escape_time.sv]
// Top level of the Mandelbrot escape-time block.
`timescale 1ns / 1ps

// Takes one pixel coordinate c (two signed fixed-point values with FRAC_BITS
// fraction bits) and iterates z = z*z + c from z = c until |z|^2 reaches 4 or
// the count reaches the limit in csr_wdata (reset value 100). One item is in
// flight at a time: the next item is accepted only once the current result has
// been written to the output register and the controller is idle again. Each
// iteration passes through the three registered multipliers and then through
// the add, escape test and z update. A finished result waits in an output
// register, and the next item is accepted while it waits; an item that finishes
// while that register is still full holds until the result is taken. A limit of
// zero reports every point as bounded with count 0.
module mandelbrot_escape_time #(
   parameter int unsigned FRAC_BITS = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // c_real [31:0], c_imag [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // shade [7:0], iteration_count [15:8], escaped [16]
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata    // iteration limit
);

   met_pkg::cmd_type    cmd;
   met_pkg::status_type status;
   logic [met_pkg::COUNT_W-1:0] shade;
   logic [met_pkg::COUNT_W-1:0] iteration_count;
   logic                        escaped;

   // Controller: handshakes and iteration sequencing.
   met_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Datapath: arithmetic, limit register and result register.
   met_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_tdata       (req_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .shade           (shade),
      .iteration_count (iteration_count),
      .escaped         (escaped)
   );

   // Result fields packed from the lowest bit up, padded to whole bytes.
   assign rsp_tdata = {7'd0, escaped, iteration_count, shade};

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned FRAC_BITS = 28;
   localparam int ONE_Q = 1 << FRAC_BITS;
   localparam int COORD_MIN = 32'sh8000_0000;
   localparam int COORD_MAX = 32'sh7FFF_FFFF;

   // Sampling box around the set: real -2.1 .. 0.6, imaginary -1.2 .. 1.2.
   localparam int BOX_RE_LO = -(2 * ONE_Q + ONE_Q / 10);
   localparam int unsigned BOX_RE_SPAN = 2 * ONE_Q + (ONE_Q / 10) * 7;
   localparam int BOX_IM_HALF = ONE_Q + ONE_Q / 5;

   // Drain time after the last result, a little longer than the slowest item under the largest limit.
   localparam int unsigned DRAIN_CYCLES = 2 * 255 + 3 + 32;
   // Watchdog bound for the slowest legal run of about 850 items.
   localparam int unsigned CYCLE_LIMIT = 3_000_000;

   // Input item and result item, laid out as on the bus.
   typedef struct packed {
      logic signed [met_pkg::COORD_W-1:0] c_imag;
      logic signed [met_pkg::COORD_W-1:0] c_real;
   } coord_type;

   typedef struct packed {
      logic                        escaped;
      logic [met_pkg::COUNT_W-1:0] iteration_count;
      logic [met_pkg::COUNT_W-1:0] shade;
   } escape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // c_real [31:0], c_imag [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // shade [7:0], iteration_count [15:8], escaped [16]
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;   // iteration limit

   coord_type                   pending_coords[$];
   escape_type                  expected_escapes[$];
   logic [met_pkg::COUNT_W-1:0] limit_model = met_pkg::MAX_ITER_RESET;
   int unsigned                 idle_pct = 0;
   int unsigned                 send_gap = 0;
   int unsigned                 recv_gap = 0;
   int unsigned                 items_sent = 0;
   int unsigned                 results_checked = 0;
   int unsigned                 escaped_seen = 0;
   int unsigned                 bounded_seen = 0;
   int unsigned                 saturated_seen = 0;
   int unsigned                 limits_used = 1;
   int unsigned                 error_count = 0;

   always #10 clock = ~clock;

   mandelbrot_escape_time #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   // Full-width product, then arithmetic shift right: rounds toward minus infinity.
   function automatic longint floor_product(longint a, longint b, int unsigned shift);
      logic signed [127:0] wide_a;
      logic signed [127:0] wide_b;
      logic signed [127:0] product;
      wide_a = a;
      wide_b = b;
      product = wide_a * wide_b;
      return longint'(product >>> shift);
   endfunction

   // Escape-time iteration for one coordinate under the given limit.
   function automatic escape_type predict_escape(coord_type c,
                                                 logic [met_pkg::COUNT_W-1:0] limit);
      longint      cr;
      longint      ci;
      longint      zr;
      longint      zi;
      longint      zr_sq;
      longint      zi_sq;
      longint      cross_term;
      longint      four_q;
      int unsigned count;
      int unsigned shade_sum;
      escape_type  result;
      cr = c.c_real;
      ci = c.c_imag;
      zr = cr;
      zi = ci;
      four_q = longint'(4) <<< FRAC_BITS;
      count = 0;
      while (1'b1) begin
         zr_sq = floor_product(zr, zr, FRAC_BITS);
         zi_sq = floor_product(zi, zi, FRAC_BITS);
         if (zr_sq + zi_sq >= four_q || count == limit) break;
         cross_term = floor_product(zr, zi, FRAC_BITS - 1);
         zr = zr_sq - zi_sq + cr;
         zi = cross_term + ci;
         count++;
      end
      // Reaching the limit wins over escaping on the same test.
      result.iteration_count = count[met_pkg::COUNT_W-1:0];
      result.escaped = (count != limit);
      if (result.escaped) begin
         shade_sum = count + count / 5;
         result.shade = (shade_sum > met_pkg::SHADE_MAX) ?
                        met_pkg::SHADE_MAX : shade_sum[met_pkg::COUNT_W-1:0];
      end else begin
         result.shade = met_pkg::SHADE_MAX;
      end
      return result;
   endfunction

   function automatic void queue_coord(int re, int im);
      coord_type item;
      item.c_real = re;
      item.c_imag = im;
      pending_coords.push_back(item);
   endfunction

   // Mostly points near the set or its slow regions, with some raw noise.
   function automatic coord_type random_coord();
      coord_type   item;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         item.c_real = BOX_RE_LO + int'($urandom_range(0, BOX_RE_SPAN));
         item.c_imag = -BOX_IM_HALF + int'($urandom_range(0, 2 * BOX_IM_HALF));
      end else if (pick < 7) begin
         // Just right of the cusp at 0.25: escapes after a very long run.
         item.c_real = ONE_Q / 4 + int'($urandom_range(20000, 120000));
         item.c_imag = int'($urandom_range(0, 8192)) - 4096;
      end else if (pick < 8) begin
         // Close to the neck at -0.75: slow escape off the real axis.
         item.c_real = -(ONE_Q / 4) * 3 + int'($urandom_range(0, 2000)) - 1000;
         item.c_imag = int'($urandom_range(1 << 20, 1 << 24));
         if ($urandom_range(0, 1) == 1) item.c_imag = -item.c_imag;
      end else begin
         item = {$urandom, $urandom};
      end
      return item;
   endfunction

   // Looks after the clock edge has settled so a just-presented item is seen.
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_coords.size() > 0 || req_tvalid || expected_escapes.size() > 0);
   endtask

   // Limit writes only happen while nothing is in flight.
   task automatic write_limit(logic [met_pkg::COUNT_W-1:0] limit);
      @(posedge clock);
      csr_wdata <= limit;
      csr_we <= 1'b1;
      limit_model = limit;
      limits_used++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [met_pkg::COUNT_W-1:0] limit, int unsigned pct,
                            int unsigned count);
      wait_idle();
      write_limit(limit);
      idle_pct = pct;
      // A few fixed points each time: origin, escape exactly at the limit when it is one,
      // magnitude exactly two, far corner and the cusp.
      queue_coord(0, 0);
      queue_coord(ONE_Q, 0);
      queue_coord(-2 * ONE_Q, 0);
      queue_coord(COORD_MAX, COORD_MIN);
      queue_coord(ONE_Q / 4, 0);
      repeat (count) pending_coords.push_back(random_coord());
   endtask

   // Input side: presents queued items, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_escapes.push_back(predict_escape(coord_type'(req_tdata), limit_model));
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_coords.size() > 0) begin
               req_tdata <= pending_coords.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 13);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side: stalls at random and checks each accepted item in order.
   always @(posedge clock) begin
      escape_type got;
      escape_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = escape_type'(rsp_tdata[16:0]);
            if (expected_escapes.size() == 0) begin
               $error("Unexpected result item: shade %0d, iteration_count %0d, escaped %0d",
                      got.shade, got.iteration_count, got.escaped);
               error_count++;
            end else begin
               want = expected_escapes.pop_front();
               results_checked++;
               if (got.shade !== want.shade) begin
                  $error("shade: expected %0d, got %0d", want.shade, got.shade);
                  error_count++;
               end
               if (got.iteration_count !== want.iteration_count) begin
                  $error("iteration_count: expected %0d, got %0d",
                         want.iteration_count, got.iteration_count);
                  error_count++;
               end
               if (got.escaped !== want.escaped) begin
                  $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
                  error_count++;
               end
               if (want.escaped) begin
                  escaped_seen++;
                  if (want.shade == met_pkg::SHADE_MAX) saturated_seen++;
               end else begin
                  bounded_seen++;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < idle_pct) recv_gap = $urandom_range(1, 13);
         end
      end
   end

   // Watchdog for a block that stops answering.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               CYCLE_LIMIT, expected_escapes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Sequence of limit settings with directed and random coordinates.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed points under the reset limit.
      idle_pct = 15;
      queue_coord(0, 0);
      queue_coord(-2 * ONE_Q, 0);
      queue_coord(-2 * ONE_Q - 1, 0);
      queue_coord(-2 * ONE_Q + 1, 0);
      queue_coord(ONE_Q, 0);
      queue_coord(ONE_Q / 4, 0);
      queue_coord(-ONE_Q, 0);
      queue_coord(0, ONE_Q);
      queue_coord(-(ONE_Q / 4) * 3, ONE_Q / 20);
      queue_coord(ONE_Q / 4 + ONE_Q / 100, 0);
      queue_coord((ONE_Q / 10) * 3, ONE_Q / 2);
      queue_coord(1, -1);
      queue_coord(COORD_MIN, COORD_MIN);
      queue_coord(COORD_MAX, COORD_MAX);
      queue_coord(COORD_MIN, COORD_MAX);
      queue_coord(COORD_MAX, COORD_MIN);
      queue_coord(COORD_MIN, 0);
      queue_coord(0, COORD_MAX);

      run_phase(8'd1, 30, 120);
      run_phase(8'd0, 10, 70);
      run_phase(8'd255, 20, 120);
      run_phase(8'd212, 0, 120);
      run_phase(8'($urandom_range(2, 254)), 40, 120);
      run_phase(8'd37, 25, 120);
      // Last part runs at full rate on both sides.
      run_phase(met_pkg::MAX_ITER_RESET, 0, 120);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results for %0d coordinates across %0d limit settings.",
               results_checked, items_sent, limits_used);
      $display("%0d points escaped (%0d with a clipped shade), %0d stopped at the limit.",
               escaped_seen, saturated_seen, bounded_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
